// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the frame signature block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define FSC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define FSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== rtl/core/fsc_pkg.sv =====
// Types, constants and the CRC byte function of the frame signature block.
package fsc_pkg;

  localparam int PIXEL_COUNT_BITS  = 24;
  // Sample count must stay a power of two: positions are built with shifts.
  localparam int SAMPLE_WORD_COUNT = 4;
  localparam int SAMPLE_COUNT      = 4 * SAMPLE_WORD_COUNT;
  localparam int SAMPLE_SHIFT      = $clog2(SAMPLE_COUNT);
  localparam int POS_PROD_W        = PIXEL_COUNT_BITS + SAMPLE_SHIFT;
  localparam int OUT_WORDS         = 4;

  localparam int DIM_W      = 12;
  localparam int PIXEL_W    = 8;
  localparam int COLOR_COUNT = 1 << PIXEL_W;
  localparam int DISTINCT_W = PIXEL_W + 1;
  localparam int CRC_W      = 32;
  localparam int PROD_W     = 2 * DIM_W;
  localparam int TOTAL_EXT_W = (PIXEL_COUNT_BITS > PROD_W) ? PIXEL_COUNT_BITS : PROD_W;

  localparam logic [PIXEL_COUNT_BITS-1:0] COUNT_MAX = {PIXEL_COUNT_BITS{1'b1}};

  localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;

  localparam logic [DIM_W-1:0] RESET_WIDTH  = 12'd320;
  localparam logic [DIM_W-1:0] RESET_HEIGHT = 12'd200;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  // Cycles the position tables need after a register write.
  localparam int SETTLE_W = 2;
  localparam logic [SETTLE_W-1:0] SETTLE_CYCLES = 2'd2;

  // Queue between front and back; depth is a power of two.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Operation codes carried in the queue.
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_REARM = 1'b1;

  typedef struct packed {
    logic               command;
    logic [PIXEL_W-1:0] pixel;
  } in_item_t;

  typedef struct packed {
    logic [CRC_W-1:0]      frame_crc;
    logic [DISTINCT_W-1:0] distinct_colors;
    logic [31:0]           sample_word_0;
    logic [31:0]           sample_word_1;
    logic [31:0]           sample_word_2;
    logic [31:0]           sample_word_3;
    logic                  uniform_frame;
  } out_item_t;

  typedef struct packed {
    logic               kind;
    logic [PIXEL_W-1:0] pixel;
  } op_t;

  typedef struct packed {
    logic [PIXEL_COUNT_BITS-1:0]                   total;
    logic [SAMPLE_COUNT-1:0][PIXEL_COUNT_BITS-1:0] pos;
  } frame_cfg_t;

  typedef struct packed {
    logic                  capture_done;
    logic [DISTINCT_W-1:0] distinct_count;
    logic                  result_load;
    logic                  rearm_seen;
  } back_status_t;

  // Reflected CRC-32 update over one byte, bit by bit.
  function automatic logic [CRC_W-1:0] crc32_byte(input logic [CRC_W-1:0] crc,
                                                 input logic [PIXEL_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {{(CRC_W-PIXEL_W){1'b0}}, b};
    for (int k = 0; k < PIXEL_W; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {CRC_W{c[0]}});
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/fsc_cfg.sv =====
// Frame size registers, pixel total and sample position table.
module fsc_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [fsc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fsc_pkg::DIM_W-1:0]       cfg_wr_data,
  output fsc_pkg::frame_cfg_t             frame_cfg,
  output logic                            cfg_busy
);

  localparam int PCB = fsc_pkg::PIXEL_COUNT_BITS;
  localparam int PW  = fsc_pkg::POS_PROD_W;
  localparam int SS  = fsc_pkg::SAMPLE_SHIFT;

  logic [fsc_pkg::DIM_W-1:0]       width_r;
  logic [fsc_pkg::DIM_W-1:0]       height_r;
  logic [fsc_pkg::SETTLE_W-1:0]    settle_r;
  logic [PCB-1:0]                  total_r;
  logic [fsc_pkg::TOTAL_EXT_W-1:0] prod_ext;
  logic [PCB-1:0]                  total_nxt;
  logic [fsc_pkg::SAMPLE_COUNT-1:0][PCB-1:0] pos_r;
  logic [fsc_pkg::SAMPLE_COUNT-1:0][PCB-1:0] pos_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= fsc_pkg::RESET_WIDTH;
      height_r <= fsc_pkg::RESET_HEIGHT;
      settle_r <= fsc_pkg::SETTLE_CYCLES;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          fsc_pkg::REG_FRAME_WIDTH:  width_r  <= cfg_wr_data;
          fsc_pkg::REG_FRAME_HEIGHT: height_r <= cfg_wr_data;
          default: ;
        endcase
      end
      if (cfg_wr_en) begin
        settle_r <= fsc_pkg::SETTLE_CYCLES;
      end else if (settle_r != '0) begin
        settle_r <= settle_r - 1'b1;
      end
    end
  end

  // Saturate the product to the counter range.
  always_comb begin
    prod_ext = fsc_pkg::TOTAL_EXT_W'(width_r) * fsc_pkg::TOTAL_EXT_W'(height_r);
    if (prod_ext > fsc_pkg::TOTAL_EXT_W'(fsc_pkg::COUNT_MAX)) begin
      total_nxt = fsc_pkg::COUNT_MAX;
    end else begin
      total_nxt = prod_ext[PCB-1:0];
    end
  end

  // Position j = j*T/S + T/(2S), clamped to T-1.
  for (genvar j = 0; j < fsc_pkg::SAMPLE_COUNT; j++) begin : g_pos
    logic [PW-1:0]  scaled;
    logic [PCB:0]   sum;
    assign scaled = {{SS{1'b0}}, total_r} * PW'(j);
    assign sum    = {1'b0, scaled[PW-1:SS]} + {1'b0, (total_r >> (SS + 1))};
    assign pos_nxt[j] = (sum >= {1'b0, total_r}) ? (total_r - 1'b1) : sum[PCB-1:0];
  end

  always_ff @(posedge clk) begin
    total_r <= total_nxt;
    pos_r   <= pos_nxt;
  end

  assign frame_cfg.total = total_r;
  assign frame_cfg.pos   = pos_r;
  assign cfg_busy        = (settle_r != '0);

endmodule

// ===== rtl/core/fsc_front.sv =====
// Input side: accepts requests, classifies them and queues them for the back end.
module fsc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  fsc_pkg::in_item_t   in_data,
  input  logic                cfg_busy,
  input  logic                q_pop,
  output logic                q_valid,
  output fsc_pkg::op_t        q_item
);

  fsc_pkg::op_t                   entries_r [fsc_pkg::QUEUE_DEPTH];
  logic [fsc_pkg::QPTR_W-1:0]     wr_ptr_r;
  logic [fsc_pkg::QPTR_W-1:0]     rd_ptr_r;
  logic [fsc_pkg::QCNT_W-1:0]     count_r;
  logic [fsc_pkg::QCNT_W-1:0]     count_nxt;
  logic                           push;
  fsc_pkg::op_t                   op_in;

  assign in_stall = cfg_busy || (count_r == fsc_pkg::QCNT_W'(fsc_pkg::QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;

  // Classify: a rearm carries no pixel.
  always_comb begin
    op_in.kind  = in_data.command ? fsc_pkg::OP_REARM : fsc_pkg::OP_PIXEL;
    op_in.pixel = in_data.command ? '0 : in_data.pixel;
  end

  always_comb begin
    count_nxt = count_r;
    if (push && !q_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && q_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (q_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= op_in;
    end
  end

  assign q_valid = (count_r != '0);
  assign q_item  = entries_r[rd_ptr_r];

endmodule

// ===== rtl/core/fsc_back.sv =====
// Back end: CRC, color map, counter, samples and the result register.
module fsc_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    q_valid,
  input  fsc_pkg::op_t            q_item,
  output logic                    q_pop,
  input  fsc_pkg::frame_cfg_t     frame_cfg,
  output logic                    out_valid,
  input  logic                    out_stall,
  output fsc_pkg::out_item_t      out_data,
  output fsc_pkg::back_status_t   status
);

  localparam int PCB = fsc_pkg::PIXEL_COUNT_BITS;
  localparam int SC  = fsc_pkg::SAMPLE_COUNT;

  logic [fsc_pkg::CRC_W-1:0]         crc_r;
  logic [fsc_pkg::COLOR_COUNT-1:0]   seen_r;
  logic [fsc_pkg::DISTINCT_W-1:0]    distinct_r;
  logic [PCB-1:0]                    cnt_r;
  logic [SC-1:0][fsc_pkg::PIXEL_W-1:0] samp_r;
  logic                              done_r;
  logic                              out_valid_r;
  fsc_pkg::out_item_t                out_data_r;

  logic [fsc_pkg::CRC_W-1:0]         crc_nxt;
  logic [fsc_pkg::DISTINCT_W-1:0]    distinct_nxt;
  logic [PCB-1:0]                    cnt_nxt;
  logic [SC-1:0][fsc_pkg::PIXEL_W-1:0] samp_nxt;
  logic [fsc_pkg::OUT_WORDS-1:0][31:0] words;
  fsc_pkg::out_item_t                result;
  logic [fsc_pkg::PIXEL_W-1:0]       pix;
  logic                              rearm;
  logic                              active;
  logic                              frame_end;
  logic                              load;

  assign pix    = q_item.pixel;
  assign q_pop  = q_valid && !(out_valid_r && out_stall);
  assign rearm  = q_pop && (q_item.kind == fsc_pkg::OP_REARM);
  assign active = q_pop && (q_item.kind == fsc_pkg::OP_PIXEL) && !done_r &&
                  (frame_cfg.total != '0);

  assign crc_nxt      = fsc_pkg::crc32_byte(crc_r, pix);
  assign distinct_nxt = distinct_r + fsc_pkg::DISTINCT_W'(!seen_r[pix]);
  assign cnt_nxt      = (cnt_r == fsc_pkg::COUNT_MAX) ? cnt_r : cnt_r + 1'b1;
  assign frame_end    = (cnt_nxt >= frame_cfg.total);
  assign load         = active && frame_end;

  for (genvar j = 0; j < SC; j++) begin : g_samp
    assign samp_nxt[j] = (frame_cfg.pos[j] == cnt_r) ? pix : samp_r[j];
  end

  for (genvar w = 0; w < fsc_pkg::OUT_WORDS; w++) begin : g_word
    if (w < fsc_pkg::SAMPLE_WORD_COUNT) begin : g_used
      assign words[w] = {samp_nxt[4*w+3], samp_nxt[4*w+2], samp_nxt[4*w+1], samp_nxt[4*w]};
    end else begin : g_zero
      assign words[w] = '0;
    end
  end

  always_comb begin
    result.frame_crc       = ~crc_nxt;
    result.distinct_colors = distinct_nxt;
    result.sample_word_0   = words[0];
    result.sample_word_1   = words[1];
    result.sample_word_2   = words[2];
    result.sample_word_3   = words[3];
    result.uniform_frame   = (distinct_nxt <= fsc_pkg::DISTINCT_W'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n || rearm) begin
      crc_r      <= fsc_pkg::CRC_INIT;
      seen_r     <= '0;
      distinct_r <= '0;
      cnt_r      <= '0;
      samp_r     <= '0;
      done_r     <= 1'b0;
    end else if (active) begin
      crc_r       <= crc_nxt;
      seen_r[pix] <= 1'b1;
      distinct_r  <= distinct_nxt;
      cnt_r       <= cnt_nxt;
      samp_r      <= samp_nxt;
      done_r      <= frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign status.capture_done   = done_r;
  assign status.distinct_count = distinct_r;
  assign status.result_load    = load;
  assign status.rearm_seen     = rearm;

endmodule

// ===== rtl/core/frame_signature_capture_unit.sv =====
// Frame signature capture: CRC-32, distinct colors and spread samples of one frame.
// Throughput: one request per cycle while in_stall is low; the frame's last pixel is
//   written into the queue and then into the result register before out_valid rises.
// After a register write the input stalls while the position table settles.
// Reset (synchronous, rst_n low): 320x200 frame, capture state cleared, queue empty,
//   input stalled after release until the position table settles.
`include "assert_macros.svh"

module frame_signature_capture_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  fsc_pkg::in_item_t             in_data,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output fsc_pkg::out_item_t            out_data,
  // configuration write port
  input  logic                          cfg_wr_en,
  input  logic [fsc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fsc_pkg::DIM_W-1:0]     cfg_wr_data
);

  fsc_pkg::frame_cfg_t    frame_cfg;
  fsc_pkg::op_t           q_item;
  fsc_pkg::back_status_t  status;
  logic                   cfg_busy;
  logic                   q_valid;
  logic                   q_pop;

  // Hold frame size, pixel total and sample positions; flag busy while they settle.
  fsc_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wr_data(cfg_wr_data),
    .frame_cfg  (frame_cfg),
    .cfg_busy   (cfg_busy)
  );

  // Accept requests, tag pixel versus rearm, queue them.
  fsc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cfg_busy (cfg_busy),
    .q_pop    (q_pop),
    .q_valid  (q_valid),
    .q_item   (q_item)
  );

  // Drain the queue one request per cycle unless the result register is blocked.
  fsc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .frame_cfg (frame_cfg),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .status    (status)
  );

  // A register write must block input while positions are recomputed.
  `FSC_ASSERT_NEXT(a_cfg_blocks_input, clk, rst_n, cfg_wr_en, in_stall)
  // A loaded result closes the capture until rearm.
  `FSC_ASSERT_NEXT(a_load_sets_done, clk, rst_n, status.result_load, status.capture_done)
  // Rearm leaves a clean capture.
  `FSC_ASSERT_NEXT(a_rearm_clears, clk, rst_n, status.rearm_seen,
                   (status.distinct_count == '0) && !status.capture_done)
  // Uniform flag agrees with the distinct count of the result.
  `FSC_ASSERT_NOW(a_uniform_match, clk, rst_n, out_valid,
                  out_data.uniform_frame == (out_data.distinct_colors <= 9'd1))

endmodule
